### rtl/nlp_pkg.sv
// Shared constants and types for the lexicographic permutation lister.
// Depends on nothing; imported by next_lexicographic_permutation.
package nlp_pkg;

  // number of stored digit positions
  localparam int unsigned MAX_LEN = 8;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LEN_W = $clog2(MAX_LEN + 1);
  localparam int unsigned CFG_W = 4;
  localparam int unsigned PERM_W = 32;
  localparam int unsigned PACK_DIGITS = (MAX_LEN < 8) ? MAX_LEN : 8;
  localparam logic [CFG_W-1:0] LEN_RESET = CFG_W'(8);

  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [LEN_W-1:0] len_t;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_PIV_LOAD = 8'b0000_0010,
    ST_PIV_SCAN = 8'b0000_0100,
    ST_EMIT     = 8'b0000_1000,
    ST_SUCC     = 8'b0001_0000,
    ST_SWAP     = 8'b0010_0000,
    ST_REV_A    = 8'b0100_0000,
    ST_REV_B    = 8'b1000_0000
  } state_e;

endpackage

### rtl/next_lexicographic_permutation.sv
// Top level of the lexicographic permutation lister: digit store, sequencer,
// single-read-port compare unit and output register. Depends on nlp_pkg.
//
// Each request transfer emits the stored permutation of 1..n (n from the
// length register, 0 read as 1, values above MAX_LEN saturated), four bits per
// digit with the first digit lowest, tlast set when it is the final descending
// one and tuser set when the list was already exhausted; the stored
// permutation then advances to its lexicographic successor. A request with
// restart set reloads the identity first, and must follow any length write.
// The digit store has one read port, so the sequencer walks it one digit per
// cycle: it accepts the request, searches for the pivot from the right, emits
// and then, unless no pivot was found or the list is exhausted, searches for
// the successor, swaps, and reverses the suffix pair by pair, holding one end
// in ST_REV_A and swapping the pair in ST_REV_B. The input is ready only while
// the sequencer idles; a finished result waits in the output register while
// the next request is taken and searched, and the emit step stalls until that
// register is free.
module next_lexicographic_permutation
  import nlp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // length register write
  input  logic              cfg_we_i,
  input  logic [CFG_W-1:0]  cfg_wdata_i,
  // request stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [0] restart, [7:1] zero
  // result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PERM_W-1:0] m_axis_tdata,   // [31:0] perm_packed
  output logic              m_axis_tlast,   // is_last
  output logic              m_axis_tuser    // exhausted
);

  state_e          state_q, state_d;
  logic [CFG_W-1:0] len_q;
  digit_t          digits_q [MAX_LEN];
  logic            done_q;

  idx_t            idx_q;      // pivot scan position
  digit_t          prev_q;     // digit right of the scan position
  idx_t            piv_idx_q;
  digit_t          piv_val_q;
  logic            found_q;
  len_t            m_q;        // successor scan position
  idx_t            best_q;
  digit_t          best_val_q;
  idx_t            r_q, s_q;   // reversal ends
  digit_t          tmp_q;

  logic            out_valid_q;
  logic [PERM_W-1:0] out_data_q;
  logic            out_last_q, out_user_q;

  len_t            n_eff;
  idx_t            n_last;
  idx_t            rd_idx;
  digit_t          rd_data;
  logic [PERM_W-1:0] packed_perm;
  logic            in_xfer;
  len_t            succ_start;
  idx_t            r_nx, s_nx;

  // effective length: zero acts as one, large values saturate
  always_comb begin
    if (len_q == '0) begin
      n_eff = len_t'(1);
    end else if (len_q > CFG_W'(MAX_LEN)) begin
      n_eff = len_t'(MAX_LEN);
    end else begin
      n_eff = len_q[LEN_W-1:0];
    end
  end
  assign n_last = idx_t'(n_eff - len_t'(1));

  // single read port of the digit store
  always_comb begin
    case (state_q)
      ST_PIV_LOAD: rd_idx = n_last;
      ST_PIV_SCAN: rd_idx = idx_q;
      ST_SUCC:     rd_idx = m_q[IDX_W-1:0];
      ST_REV_A:    rd_idx = r_q;
      ST_REV_B:    rd_idx = s_q;
      default:     rd_idx = '0;
    endcase
  end
  assign rd_data = digits_q[rd_idx];

  // packing of the first n digits, first digit lowest
  always_comb begin
    packed_perm = '0;
    for (int unsigned i = 0; i < PACK_DIGITS; i++) begin
      if (len_t'(i) < n_eff) begin
        packed_perm[DIGIT_W*i +: DIGIT_W] = digits_q[i];
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign succ_start = len_t'(piv_idx_q) + len_t'(2);
  assign r_nx = r_q + idx_t'(1);
  assign s_nx = s_q - idx_t'(1);

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = ST_PIV_LOAD;
      end
      ST_PIV_LOAD: begin
        state_d = (n_eff == len_t'(1)) ? ST_EMIT : ST_PIV_SCAN;
      end
      ST_PIV_SCAN: begin
        if (rd_data < prev_q || idx_q == '0) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q) begin
          if (done_q || !found_q) begin
            state_d = ST_IDLE;
          end else if (succ_start < n_eff) begin
            state_d = ST_SUCC;
          end else begin
            state_d = ST_SWAP;
          end
        end
      end
      ST_SUCC: begin
        if (m_q[IDX_W-1:0] == n_last) state_d = ST_SWAP;
      end
      ST_SWAP: begin
        state_d = (piv_idx_q + idx_t'(1) < n_last) ? ST_REV_A : ST_IDLE;
      end
      ST_REV_A: state_d = ST_REV_B;
      ST_REV_B: begin
        state_d = (r_nx < s_nx) ? ST_REV_A : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= LEN_RESET;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) len_q <= cfg_wdata_i;
      if (in_xfer && s_axis_tdata[0]) begin
        done_q <= 1'b0;
      end else if (state_q == ST_EMIT && !out_valid_q && !found_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // digit store: identity on reset and restart, swap and reversal writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned i = 0; i < MAX_LEN; i++) begin
        digits_q[i] <= digit_t'(i + 1);
      end
    end else begin
      if (in_xfer && s_axis_tdata[0]) begin
        for (int unsigned i = 0; i < MAX_LEN; i++) begin
          digits_q[i] <= digit_t'(i + 1);
        end
      end else if (state_q == ST_SWAP) begin
        digits_q[piv_idx_q] <= best_val_q;
        digits_q[best_q]    <= piv_val_q;
      end else if (state_q == ST_REV_B) begin
        digits_q[r_q] <= rd_data;
        digits_q[s_q] <= tmp_q;
      end
    end
  end

  // search and reversal datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_PIV_LOAD: begin
        prev_q  <= rd_data;
        idx_q   <= idx_t'(n_eff - len_t'(2));
        found_q <= 1'b0;
      end
      ST_PIV_SCAN: begin
        if (rd_data < prev_q) begin
          found_q   <= 1'b1;
          piv_idx_q <= idx_q;
          piv_val_q <= rd_data;
          best_q    <= idx_q + idx_t'(1);
          best_val_q <= prev_q;
          m_q       <= len_t'(idx_q) + len_t'(2);
        end else begin
          prev_q <= rd_data;
          idx_q  <= idx_q - idx_t'(1);
        end
      end
      ST_SUCC: begin
        if (rd_data > piv_val_q && rd_data < best_val_q) begin
          best_q     <= m_q[IDX_W-1:0];
          best_val_q <= rd_data;
        end
        m_q <= m_q + len_t'(1);
      end
      ST_SWAP: begin
        r_q <= piv_idx_q + idx_t'(1);
        s_q <= n_last;
      end
      ST_REV_A: tmp_q <= rd_data;
      ST_REV_B: begin
        r_q <= r_nx;
        s_q <= s_nx;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_EMIT && !out_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMIT && !out_valid_q) begin
      out_data_q <= packed_perm;
      out_last_q <= !found_q;
      out_user_q <= done_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### bench/next_lexicographic_permutation_test.sv
// Testbench for next_lexicographic_permutation: directed and random request
// streams, checked against an in-bench permutation predictor. Needs nlp_pkg.
module next_lexicographic_permutation_test;
  import nlp_pkg::*;

  localparam int unsigned RANDOM_ITEMS  = 1500;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned CYCLE_LIMIT   = 1000000;
  localparam int unsigned MAX_PRINTED   = 100;

  typedef struct packed {
    logic [PERM_W-1:0] perm;
    logic              last;
    logic              exh;
  } perm_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [PERM_W-1:0] m_tdata;
  logic              m_tlast;
  logic              m_tuser;

  // predictor state
  digit_t            perm_store [MAX_LEN];
  logic              perm_done;
  logic [CFG_W-1:0]  len_reg;

  perm_result_t      pending_perms [$];
  int unsigned       error_count = 0;
  int unsigned       random_sent = 0;
  int unsigned       cycle_count = 0;
  logic              no_gaps = 1'b0;
  logic              hold_request = 1'b0;

  next_lexicographic_permutation dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [0] restart
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // [31:0] perm_packed
    .m_axis_tlast  (m_tlast),   // is_last
    .m_axis_tuser  (m_tuser)    // exhausted
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("next_lexicographic_permutation test failed");
      $finish;
    end
  end

  function automatic void load_identity();
    for (int unsigned i = 0; i < MAX_LEN; i++) perm_store[i] = digit_t'(i + 1);
  endfunction

  // emit the stored permutation, then step to its lexicographic successor
  function automatic perm_result_t emit_and_advance(input logic restart);
    perm_result_t res;
    int unsigned  n, i, j, best, r, s;
    digit_t       t;
    n = (len_reg == 0) ? 1 : ((len_reg > MAX_LEN) ? MAX_LEN : len_reg);
    if (restart) begin
      load_identity();
      perm_done = 1'b0;
    end
    res.perm = '0;
    for (i = 0; i < n && i < 8; i++) res.perm[4*i +: 4] = perm_store[i];
    // rightmost pivot, n when none
    j = n;
    for (i = n - 1; i > 0; i--) begin
      if (perm_store[i-1] < perm_store[i]) begin
        j = i - 1;
        break;
      end
    end
    res.last = (j == n);
    res.exh  = perm_done;
    if (!perm_done) begin
      if (j == n) begin
        perm_done = 1'b1;
      end else begin
        // leftmost smallest digit right of the pivot that beats it
        best = j + 1;
        for (i = j + 2; i < n; i++) begin
          if (perm_store[i] > perm_store[j] && perm_store[i] < perm_store[best]) best = i;
        end
        t = perm_store[j];
        perm_store[j] = perm_store[best];
        perm_store[best] = t;
        r = j + 1;
        s = n - 1;
        while (r < s) begin
          t = perm_store[r];
          perm_store[r] = perm_store[s];
          perm_store[s] = t;
          r++;
          s--;
        end
      end
    end
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MAX_PRINTED) $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // one request transfer; valid stays high for back-to-back requests
  task automatic send_request(input logic restart);
    int unsigned gap;
    gap = pick_gap();
    pending_perms.push_back(emit_and_advance(restart));
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, restart};
    do @(posedge clk); while (!s_tready);
  endtask

  // wait for the block to drain and finish its advance, then write the length
  task automatic write_length(input logic [CFG_W-1:0] value);
    s_tvalid <= 1'b0;
    while (pending_perms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    len_reg    = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // result sink with random stalls and an occasional long hold-off
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          m_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    perm_result_t want;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_perms.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", m_tdata));
      end else begin
        want = pending_perms.pop_front();
        if (m_tdata !== want.perm)
          report_mismatch($sformatf("perm %h, want %h", m_tdata, want.perm));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("is_last %b, want %b", m_tlast, want.last));
        if (m_tuser !== want.exh)
          report_mismatch($sformatf("exhausted %b, want %b", m_tuser, want.exh));
      end
    end
  end

  // reset state: identity of eight digits, then its first successor
  task automatic test_reset_state();
    send_request(1'b0);
    send_request(1'b0);
  endtask

  // a single digit is final at once and exhausted afterwards; zero acts as one
  task automatic test_short_lengths();
    write_length(CFG_W'(1));
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    write_length(CFG_W'(0));
    send_request(1'b1);
    send_request(1'b0);
  endtask

  // full list of three digits, exhaustion, then restart clears it
  task automatic test_full_list();
    write_length(CFG_W'(3));
    send_request(1'b1);
    repeat (7) send_request(1'b0);
    send_request(1'b1);
  endtask

  // lengths above the digit count saturate
  task automatic test_saturation();
    write_length(CFG_W'(15));
    send_request(1'b1);
    send_request(1'b0);
    write_length(CFG_W'(9));
    send_request(1'b1);
  endtask

  // shorter length continues from the stored digits as they stand
  task automatic test_length_change_kept();
    write_length(CFG_W'(8));
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    write_length(CFG_W'(4));
    repeat (3) send_request(1'b0);
  endtask

  // sink holds off while requests keep coming, so the block stalls its input
  task automatic test_output_backpressure();
    write_length(CFG_W'(4));
    no_gaps = 1'b1;
    hold_request = 1'b1;
    while (hold_request) @(posedge clk);
    send_request(1'b1);
    repeat (11) send_request(1'b0);
    no_gaps = 1'b0;
  endtask

  // random lengths, mostly small enough to run to exhaustion
  task automatic test_random_sequences();
    int unsigned r, n, count, perms;
    logic [CFG_W-1:0] len_val;
    logic keep_digits;
    while (random_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 70)      len_val = CFG_W'($urandom_range(1, 5));
      else if (r < 85) len_val = CFG_W'($urandom_range(6, 8));
      else if (r < 92) len_val = '0;
      else             len_val = CFG_W'($urandom_range(9, 15));
      keep_digits = ($urandom_range(0, 9) == 0);
      write_length(len_val);
      no_gaps = ($urandom_range(0, 3) == 0);
      n = (len_val == 0) ? 1 : ((len_val > MAX_LEN) ? MAX_LEN : len_val);
      if (n <= 5) begin
        perms = 1;
        for (int unsigned k = 2; k <= n; k++) perms *= k;
        count = perms + $urandom_range(0, 4);
      end else begin
        count = $urandom_range(5, 40);
      end
      send_request(!keep_digits);
      for (int unsigned k = 1; k < count; k++) send_request($urandom_range(0, 49) == 0);
      random_sent += count;
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    load_identity();
    perm_done = 1'b0;
    len_reg   = LEN_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_short_lengths();
    test_full_list();
    test_saturation();
    test_length_change_kept();
    test_output_backpressure();
    test_random_sequences();
    s_tvalid <= 1'b0;
    while (pending_perms.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("next_lexicographic_permutation test passed");
    end else begin
      $display("next_lexicographic_permutation test failed");
    end
    $finish;
  end

endmodule
